// ===== rtl/lms_adaptive_fir_filter_assert.svh =====
// ----------------------------------------------------------------------------
// LMS FIR assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef LMS_ADAPTIVE_FIR_FILTER_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lms_fir_pkg.sv =====
// ----------------------------------------------------------------------------
// LMS FIR package
// Field widths, fixed-point scaling, register and opcode codes, payload
// structs and the sequencer state type.
// ----------------------------------------------------------------------------
package lms_fir_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 24;
    localparam int STEP_WIDTH     = 16;
    localparam int TAP_CNT_WIDTH  = 7;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 1;

    // Q formats: samples Q1.(SW-1), coefficients Q4.(CW-4), step Q0.16
    localparam int COEF_FRAC   = COEF_WIDTH - 4;
    localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 1;
    localparam int Y_SHIFT     = COEF_FRAC;
    localparam int UPD_SHIFT   = STEP_WIDTH + 2 * SAMPLE_FRAC - COEF_FRAC;

    // step * error, signed
    localparam int GAIN_WIDTH  = STEP_WIDTH + 1 + SAMPLE_WIDTH;
    localparam int MUL_A_WIDTH = (GAIN_WIDTH > COEF_WIDTH) ? GAIN_WIDTH : COEF_WIDTH;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + SAMPLE_WIDTH;
    localparam int DELTA_WIDTH = PROD_WIDTH + 1 - UPD_SHIFT;

    localparam logic [STEP_WIDTH-1:0]    STEP_RESET = 16'd328;
    localparam logic [TAP_CNT_WIDTH-1:0] TAP_RESET  = 7'd32;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_STEP_SIZE = 1'b0,
        REG_TAP_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                           opcode;
        logic signed [SAMPLE_WIDTH-1:0] new_sample;
        logic signed [SAMPLE_WIDTH-1:0] desired_sample;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
        logic signed [SAMPLE_WIDTH-1:0] error_sample;
        logic signed [SAMPLE_WIDTH-1:0] oldest_sample;
        logic                           saturated;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_DRAIN,
        ST_ROUND,
        ST_ERROR,
        ST_GAIN,
        ST_LOAD_GAIN,
        ST_UPD,
        ST_UPD_DRAIN,
        ST_DONE
    } lms_state_t;

endpackage

// ===== rtl/lms_adaptive_fir_filter.sv =====
// ----------------------------------------------------------------------------
// LMS adaptive FIR filter
// Fixed-point LMS filter built around one shared multiplier and a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): one transaction carries an
//   opcode, a new sample and a desired sample. A clear transaction empties the
//   window, the coefficients and the fill count and returns nothing. A sample
//   transaction shifts the sample into the window; while the window holds
//   fewer than taps samples it returns nothing.
//   result channel (result_valid/result_ready/result): y, the error, the oldest
//   window sample and the saturation flag, held in an output register.
//   The multiplier makes one pass over the taps for y and a second pass for
//   the coefficient updates, one tap per cycle, and item_ready is low
//   meanwhile. A new item may be accepted while the last result still waits;
//   if the receiver stalls, the next result holds in the sequencer until the
//   output register frees.
//   Reset: window and coefficients read as zero, fill count zero, step_size
//   328, tap_count 32. Registers are written through cfg_we/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
`include "lms_adaptive_fir_filter_assert.svh"

module lms_adaptive_fir_filter
    import lms_fir_pkg::*;
#(
    parameter int MAX_TAPS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  item_t                     item,
    input  logic                      item_valid,
    output logic                      item_ready,
    output result_t                   result,
    output logic                      result_valid,
    input  logic                      result_ready,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = SAMPLE_WIDTH + COEF_WIDTH + ADDR_W;
    localparam int YR_W   = ACC_W + 1;
    localparam int YS_W   = YR_W - Y_SHIFT;
    localparam int ER_W   = SAMPLE_WIDTH + 1;
    localparam int DR_W   = PROD_WIDTH + 1;
    localparam int CS_W   = ((DELTA_WIDTH > COEF_WIDTH) ? DELTA_WIDTH : COEF_WIDTH) + 1;

    localparam logic [CNT_W-1:0] TAPS_MAX = CNT_W'(MAX_TAPS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0]   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0]   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam logic signed [YR_W-1:0]         Y_HALF     = YR_W'(1) << (Y_SHIFT - 1);
    localparam logic signed [DR_W-1:0]         UPD_HALF   = DR_W'(1) << (UPD_SHIFT - 1);

    // ------------------------------------------------------------------------
    // Configuration registers and sequencer state
    // ------------------------------------------------------------------------
    logic [STEP_WIDTH-1:0]    step_reg;
    logic [TAP_CNT_WIDTH-1:0] tap_count_reg;
    lms_state_t               state_reg, state_next;

    logic [CNT_W-1:0]  taps_eff;
    logic [CNT_W-1:0]  taps_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [ADDR_W-1:0] idx_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_reg, d_reg;

    // Window and coefficient storage; a cleared entry reads as zero until
    // written, tracked by one valid bit per entry.
    logic signed [SAMPLE_WIDTH-1:0] dly_mem  [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]            dly_valid_reg;
    logic [MAX_TAPS-1:0]            coef_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] dly_rd_reg;
    logic signed [COEF_WIDTH-1:0]   coef_rd_reg;
    logic                           dly_rvld_reg, coef_rvld_reg;

    // Tap pipeline: s1 = read data, s2 = product, s3 = rounded update
    logic              s1_vld_reg, s1_upd_reg, s1_last_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic              s2_vld_reg, s2_upd_reg;
    logic [ADDR_W-1:0] s2_idx_reg;
    logic              s3_vld_reg;
    logic [ADDR_W-1:0] s3_idx_reg;

    logic signed [COEF_WIDTH-1:0]   c2_reg, c3_reg;
    logic signed [DELTA_WIDTH-1:0]  delta_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg, e_reg, oldest_reg;
    logic signed [GAIN_WIDTH-1:0]   g_reg;
    logic                           sat_reg;

    result_t result_reg;
    logic    result_valid_reg;

    // ------------------------------------------------------------------------
    // Control decode
    // ------------------------------------------------------------------------
    logic item_accept;
    logic issue, issue_last, pipe_busy, result_load;

    logic [ADDR_W-1:0] dly_raddr;

    logic signed [SAMPLE_WIDTH-1:0] w_s1;
    logic signed [COEF_WIDTH-1:0]   c_s1;
    logic signed [MUL_A_WIDTH-1:0]  mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;

    logic signed [YR_W-1:0]         y_sum;
    logic signed [YS_W-1:0]         y_shift;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_ovf;
    logic signed [ER_W-1:0]         e_full;
    logic signed [SAMPLE_WIDTH-1:0] e_sat;
    logic                           e_ovf;
    logic signed [DR_W-1:0]         d_sum;
    logic signed [DELTA_WIDTH-1:0]  delta_next;
    logic signed [CS_W-1:0]         c_sum;
    logic signed [COEF_WIDTH-1:0]   c_new;
    logic                           c_ovf;

    // Clamp tap_count into 1..MAX_TAPS
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_eff = CNT_ONE;
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            taps_eff = TAPS_MAX;
        end
        else
        begin
            taps_eff = CNT_W'(tap_count_reg);
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && (item.opcode == OP_SAMPLE))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (issue_last)
                begin
                    state_next = ST_MAC_DRAIN;
                end
            end
            ST_MAC_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    // window still filling: no result
                    state_next = (fill_reg < taps_reg) ? ST_IDLE : ST_ROUND;
                end
            end
            ST_ROUND:     state_next = ST_ERROR;
            ST_ERROR:     state_next = ST_GAIN;
            ST_GAIN:      state_next = ST_LOAD_GAIN;
            ST_LOAD_GAIN: state_next = ST_UPD;
            ST_UPD:
            begin
                if (issue_last)
                begin
                    state_next = ST_UPD_DRAIN;
                end
            end
            ST_UPD_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        item_ready  = (state_reg == ST_IDLE);
        issue       = (state_reg == ST_MAC) || (state_reg == ST_UPD);
        issue_last  = issue && (CNT_W'(idx_reg) == (taps_reg - CNT_ONE));
        pipe_busy   = s1_vld_reg || s2_vld_reg || s3_vld_reg;
        result_load = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);
        // first pass reads one ahead to shift the window down
        dly_raddr   = (state_reg == ST_MAC) ? (idx_reg + ADDR_W'(1)) : idx_reg;
    end

    assign item_accept = item_valid && item_ready;

    // ------------------------------------------------------------------------
    // Shared datapath
    // ------------------------------------------------------------------------
    always_comb
    begin
        c_s1 = coef_rvld_reg ? coef_rd_reg : '0;
        if (s1_last_reg && !s1_upd_reg)
        begin
            w_s1 = x_reg;
        end
        else
        begin
            w_s1 = dly_rvld_reg ? dly_rd_reg : '0;
        end

        // One multiplier: gain, then g*x per tap, or c*x per tap
        if (state_reg == ST_GAIN)
        begin
            mul_a = MUL_A_WIDTH'($signed({1'b0, step_reg}));
            mul_b = e_reg;
        end
        else if (s1_upd_reg)
        begin
            mul_a = MUL_A_WIDTH'(g_reg);
            mul_b = w_s1;
        end
        else
        begin
            mul_a = MUL_A_WIDTH'(c_s1);
            mul_b = w_s1;
        end
    end

    // Round y half up, then saturate
    always_comb
    begin
        y_sum   = YR_W'(acc_reg) + Y_HALF;
        y_shift = YS_W'(y_sum >>> Y_SHIFT);
        y_ovf   = 1'b1;
        if (y_shift > YS_W'(SAMPLE_MAX))
        begin
            y_sat = SAMPLE_MAX;
        end
        else if (y_shift < YS_W'(SAMPLE_MIN))
        begin
            y_sat = SAMPLE_MIN;
        end
        else
        begin
            y_sat = SAMPLE_WIDTH'(y_shift);
            y_ovf = 1'b0;
        end
    end

    // Error against the saturated y
    always_comb
    begin
        e_full = ER_W'(d_reg) - ER_W'(y_reg);
        e_ovf  = 1'b1;
        if (e_full > ER_W'(SAMPLE_MAX))
        begin
            e_sat = SAMPLE_MAX;
        end
        else if (e_full < ER_W'(SAMPLE_MIN))
        begin
            e_sat = SAMPLE_MIN;
        end
        else
        begin
            e_sat = SAMPLE_WIDTH'(e_full);
            e_ovf = 1'b0;
        end
    end

    // Coefficient update: round the product, add, saturate
    always_comb
    begin
        d_sum      = DR_W'(prod_reg) + UPD_HALF;
        delta_next = DELTA_WIDTH'(d_sum >>> UPD_SHIFT);
        c_sum      = CS_W'(c3_reg) + CS_W'(delta_reg);
        c_ovf      = 1'b1;
        if (c_sum > CS_W'(COEF_MAX))
        begin
            c_new = COEF_MAX;
        end
        else if (c_sum < CS_W'(COEF_MIN))
        begin
            c_new = COEF_MIN;
        end
        else
        begin
            c_new = COEF_WIDTH'(c_sum);
            c_ovf = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_vld_reg && !s1_upd_reg)
        begin
            dly_mem[s1_idx_reg] <= w_s1;
        end
        dly_rd_reg <= dly_mem[dly_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s3_vld_reg)
        begin
            coef_mem[s3_idx_reg] <= c_new;
        end
        coef_rd_reg <= coef_mem[idx_reg];
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_RESET;
            tap_count_reg    <= TAP_RESET;
            taps_reg         <= CNT_ONE;
            fill_reg         <= '0;
            idx_reg          <= '0;
            dly_valid_reg    <= '0;
            coef_valid_reg   <= '0;
            dly_rvld_reg     <= 1'b0;
            coef_rvld_reg    <= 1'b0;
            s1_vld_reg       <= 1'b0;
            s1_upd_reg       <= 1'b0;
            s1_last_reg      <= 1'b0;
            s2_vld_reg       <= 1'b0;
            s2_upd_reg       <= 1'b0;
            s3_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEP_SIZE: step_reg      <= cfg_data[STEP_WIDTH-1:0];
                    REG_TAP_COUNT: tap_count_reg <= cfg_data[TAP_CNT_WIDTH-1:0];
                    default:       step_reg      <= step_reg;
                endcase
            end

            // Accept: clear drops all stored state at once; a sample latches
            // the tap length and advances the fill count.
            if (item_accept)
            begin
                idx_reg <= '0;
                if (item.opcode == OP_CLEAR)
                begin
                    fill_reg       <= '0;
                    dly_valid_reg  <= '0;
                    coef_valid_reg <= '0;
                end
                else
                begin
                    taps_reg <= taps_eff;
                    if (fill_reg < TAPS_MAX)
                    begin
                        fill_reg <= fill_reg + CNT_ONE;
                    end
                end
            end
            else if (issue)
            begin
                idx_reg <= issue_last ? '0 : (idx_reg + ADDR_W'(1));
            end

            if (s1_vld_reg && !s1_upd_reg)
            begin
                dly_valid_reg[s1_idx_reg] <= 1'b1;
            end
            if (s3_vld_reg)
            begin
                coef_valid_reg[s3_idx_reg] <= 1'b1;
            end

            dly_rvld_reg  <= dly_valid_reg[dly_raddr];
            coef_rvld_reg <= coef_valid_reg[idx_reg];

            // Advance the tap pipeline
            s1_vld_reg  <= issue;
            s1_upd_reg  <= (state_reg == ST_UPD);
            s1_last_reg <= issue_last;
            s2_vld_reg  <= s1_vld_reg;
            s2_upd_reg  <= s1_upd_reg;
            s3_vld_reg  <= s2_vld_reg && s2_upd_reg;

            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= idx_reg;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        c2_reg     <= c_s1;
        c3_reg     <= c2_reg;
        delta_reg  <= delta_next;
        prod_reg   <= mul_a * mul_b;

        if (item_accept)
        begin
            x_reg   <= item.new_sample;
            d_reg   <= item.desired_sample;
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (s2_vld_reg && !s2_upd_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (state_reg == ST_ROUND)
            begin
                y_reg   <= y_sat;
                sat_reg <= sat_reg | y_ovf;
            end
            if (state_reg == ST_ERROR)
            begin
                e_reg   <= e_sat;
                sat_reg <= sat_reg | e_ovf;
            end
            if (s3_vld_reg)
            begin
                sat_reg <= sat_reg | c_ovf;
            end
        end

        if (state_reg == ST_LOAD_GAIN)
        begin
            g_reg <= GAIN_WIDTH'(prod_reg);
        end

        // window tap zero after the shift
        if (s1_vld_reg && !s1_upd_reg && (s1_idx_reg == '0))
        begin
            oldest_reg <= w_s1;
        end

        if (result_load)
        begin
            result_reg.filtered_sample <= y_reg;
            result_reg.error_sample    <= e_reg;
            result_reg.oldest_sample   <= oldest_reg;
            result_reg.saturated       <= sat_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `LMS_ASSERT_SAME(a_idle_pipe_empty, item_ready,
        !(s1_vld_reg || s2_vld_reg || s3_vld_reg),
        "tap pipeline busy while accepting a transaction")

    `LMS_ASSERT_SAME(a_coef_no_collision, s3_vld_reg && (state_reg == ST_UPD),
        s3_idx_reg != idx_reg,
        "coefficient write collides with read address")

    `LMS_ASSERT_SAME(a_round_only_when_full, state_reg == ST_ROUND,
        fill_reg >= taps_reg,
        "output computed before the window is full")

    `LMS_ASSERT_NEXT(a_clear_empties, item_accept && (item.opcode == OP_CLEAR),
        (fill_reg == '0) && (dly_valid_reg == '0) && (coef_valid_reg == '0),
        "clear transaction did not empty the filter state")

endmodule
